// ===== rtl/core/mhpq_pkg.sv =====
`default_nettype none
package mhpq_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int OCC_W        = 11;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_PLACE,
    S_EX_RD,
    S_EX_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  // One heap record: the key followed by its payload.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] deaths;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
    logic [7:0]         country;
  } rec_t;

  // Finished operation handed from the sequencer to the output register.
  typedef struct packed {
    logic    load;
    status_t status;
    rec_t    rec;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/mhpq_ram.sv =====
`default_nettype none
module mhpq_ram
  import mhpq_pkg::*;
#(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire rec_t          wdata,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output rec_t               rdata0,
  output rec_t               rdata1
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mhpq_engine.sv =====
`default_nettype none
module mhpq_engine
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          op,
  input  wire rec_t          in_rec,
  input  wire logic          out_free,
  output logic               idle,
  output res_t               res,
  output logic [CW-1:0]      count,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output rec_t               wdata,
  output logic [AW-1:0]      raddr0,
  output logic [AW-1:0]      raddr1,
  input  wire rec_t          rdata0,
  input  wire rec_t          rdata1
);

  localparam int CHW = AW + 2;

  state_t        state, state_next;
  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] count_next;
  rec_t          carry, carry_next;
  rec_t          out_rec, out_rec_next;
  status_t       status, status_next;

  logic [AW-1:0]  parent;
  logic [CHW-1:0] left, right, cnt_ext;
  logic           left_ok, right_ok, take_left, take_right;
  logic [CW-1:0]  count_dec;
  logic signed [31:0] best_key;

  assign parent    = (pos - AW'(1)) >> 1;
  assign left      = CHW'({pos, 1'b1});
  assign right     = CHW'({pos, 1'b0}) + CHW'(2);
  assign cnt_ext   = CHW'(count);
  assign left_ok   = left < cnt_ext;
  assign right_ok  = right < cnt_ext;
  assign take_left = left_ok && (rdata0.key > carry.key);
  assign best_key  = take_left ? rdata0.key : carry.key;
  assign take_right = right_ok && (rdata1.key > best_key);
  assign count_dec = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    carry   <= carry_next;
    out_rec <= out_rec_next;
    status  <= status_next;
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    count_next   = count;
    carry_next   = carry;
    out_rec_next = out_rec;
    status_next  = status;
    we           = 1'b0;
    waddr        = pos;
    wdata        = carry;
    raddr0       = '0;
    raddr1       = '0;
    idle         = 1'b0;
    res.load     = 1'b0;
    res.status   = status;
    res.rec      = out_rec;

    case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          out_rec_next = '0;
          if (op == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              status_next = ST_INSERTED;
              carry_next  = in_rec;
              pos_next    = AW'(count);
              count_next  = count + CW'(1);
              state_next  = (count == '0) ? S_PLACE : S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              status_next = ST_EXTRACTED;
              state_next  = S_EX_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        raddr0     = parent;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (carry.key > rdata0.key) begin
          // Parent moves down into the hole; the hole climbs one level.
          wdata      = rdata0;
          pos_next   = parent;
          state_next = (parent == '0) ? S_PLACE : S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_EX_RD: begin
        raddr0     = '0;
        raddr1     = AW'(count_dec);
        state_next = S_EX_LOAD;
      end
      S_EX_LOAD: begin
        out_rec_next = rdata0;
        carry_next   = rdata1;
        count_next   = count_dec;
        pos_next     = '0;
        state_next   = (count_dec == '0) ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        raddr0     = left[AW-1:0];
        raddr1     = right[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (take_right) begin
          wdata      = rdata1;
          pos_next   = right[AW-1:0];
          state_next = S_DN_RD;
        end else if (take_left) begin
          wdata      = rdata0;
          pos_next   = left[AW-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/max_heap_priority_queue_unit.sv =====
// An insert places the record in the new last slot and lets it climb (read the parent, compare,
// move the parent down) until it is written; an extract reads the root and the last record, then
// sinks that record level by level; a dropped insert or an empty extract goes straight to the
// result. A stalled output adds its wait. Throughput: one item at a time; the next is taken once
// the result has been handed to the output register.
// Reset: synchronous rst empties the heap and clears the handshake state; memory is kept.
`default_nettype none
module max_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic signed [31:0] case_key,
  input  wire logic signed [31:0] death_count,
  input  wire logic [4:0]         day_of_month,
  input  wire logic [3:0]         month_number,
  input  wire logic [11:0]        year_number,
  input  wire logic [7:0]         country_id,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [31:0]      out_case_key,
  output logic signed [31:0]      out_death_count,
  output logic [4:0]              out_day,
  output logic [3:0]              out_month,
  output logic [11:0]             out_year,
  output logic [7:0]              out_country_id,
  output logic [OCC_W-1:0]        occupancy
);

  // Address width covers the memory; the count also needs to hold CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  logic          idle;
  logic          out_free;
  rec_t          in_rec;
  res_t          res;
  logic [CW-1:0] count;
  logic [CW+OCC_W-1:0] count_wide;

  logic          we;
  logic [AW-1:0] waddr, raddr0, raddr1;
  rec_t          wdata, rdata0, rdata1;

  // The sequencer takes a new item only when it is idle. A finished result waits in
  // the output register, so the next item can already be accepted meanwhile.
  assign in_ready = idle;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign in_rec.key     = case_key;
  assign in_rec.deaths  = death_count;
  assign in_rec.day     = day_of_month;
  assign in_rec.month   = month_number;
  assign in_rec.year    = year_number;
  assign in_rec.country = country_id;

  // Occupancy reports the low bits of the record count.
  assign count_wide = {{OCC_W{1'b0}}, count};

  mhpq_engine #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .op       (opcode),
    .in_rec   (in_rec),
    .out_free (out_free),
    .idle     (idle),
    .res      (res),
    .count    (count),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .rdata0   (rdata0),
    .rdata1   (rdata1)
  );

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Output register: valid is held until the item is taken. The record fields are
  // already zero for every status other than a successful extract.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status          <= res.status;
      out_case_key    <= res.rec.key;
      out_death_count <= res.rec.deaths;
      out_day         <= res.rec.day;
      out_month       <= res.rec.month;
      out_year        <= res.rec.year;
      out_country_id  <= res.rec.country;
      occupancy       <= count_wide[OCC_W-1:0];
    end
  end

endmodule
`default_nettype wire
